>>> rtl/pcce_pkg.sv
`timescale 1ns / 1ps
package pcce_pkg;
  localparam int CLOUD_DEPTH_DEF = 4096;
  localparam int COORD_W = 24;
  localparam int HEAD_W = 16;
  localparam int LIMIT_W = 16;
  localparam int CLEAR_W = 17;
  localparam int OFS_W = 25;
  localparam int SQ_W = 52;
  localparam int DIST_W = 50;
  localparam int ROOT_W = 26;
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_VX = 3'd0;
  localparam logic [2:0] REG_VY = 3'd1;
  localparam logic [2:0] REG_VZ = 3'd2;
  localparam logic [2:0] REG_HX = 3'd3;
  localparam logic [2:0] REG_HY = 3'd4;
  localparam logic [2:0] REG_HZ = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;
  localparam logic [2:0] REG_FILTER = 3'd7;

  localparam logic signed [47:0] FWD_MIN_Q22 = -48'sd209715200;
  localparam logic signed [OFS_W-1:0] SIDE_MAX_Q8 = 25'sd25600;
  localparam logic signed [ROOT_W:0] TENTH_Q8 = 27'sd26;

  // request from sequencer to shared multiplier
  typedef struct packed {
    logic signed [OFS_W-1:0] a;
    logic signed [OFS_W-1:0] b;
  } mul_req_t;
endpackage

>>> rtl/pcce_ram.sv
`timescale 1ns / 1ps
module pcce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/pcce_mul.sv
`timescale 1ns / 1ps
// shared signed 25x25 multiplier, registered product
module pcce_mul (
  input  logic                         clk,
  input  pcce_pkg::mul_req_t           req,
  output logic signed [2*pcce_pkg::OFS_W-1:0] prod
);
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end
endmodule

>>> rtl/pcce_sqrt.sv
`timescale 1ns / 1ps
// bit-pair restoring square root, one result bit a cycle, rounded to nearest
module pcce_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [pcce_pkg::SQ_W-1:0]     rad,
  output logic                          done,
  output logic [pcce_pkg::ROOT_W-1:0]   root
);
  localparam int STEPS = pcce_pkg::SQ_W / 2;
  localparam int SW = $clog2(STEPS + 1);
  logic [pcce_pkg::SQ_W-1:0] val;
  logic [pcce_pkg::ROOT_W+1:0] rem;
  logic [pcce_pkg::ROOT_W-1:0] q;
  logic [SW-1:0] step;
  logic running;
  logic [pcce_pkg::ROOT_W+1:0] trial;
  logic [pcce_pkg::ROOT_W+1:0] rem_sh;

  always_comb begin
    rem_sh = {rem[pcce_pkg::ROOT_W-1:0], val[pcce_pkg::SQ_W-1 -: 2]};
    trial = {q, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step <= '0;
        val <= rad;
        rem <= '0;
        q <= '0;
      end else if (running) begin
        val <= val << 2;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          q <= {q[pcce_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[pcce_pkg::ROOT_W-2:0], 1'b0};
        end
        if (step == SW'(STEPS - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // remainder above q rounds up
  assign root = q + pcce_pkg::ROOT_W'(rem > {2'b00, q});
endmodule

>>> rtl/point_cloud_clearance_engine.sv
`timescale 1ns / 1ps
// load: busy in F0 and STORE, plus F1 to F3 when filtering (three products, one multiplier)
// clear, unused opcode and a query of an empty store: block stays idle; the empty query answers the next cycle
// query: busy in RD, then DX, DY, DZ, ACC and SUM per stored point, then ROOT and SQRT for the square root
// one item at a time, results never wait since the receiver cannot stall; strobe as busy falls
// sync reset clears count and message state, sets registers to defaults; memory is not cleared
module point_cloud_clearance_engine #(
  parameter int CLOUD_DEPTH = pcce_pkg::CLOUD_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] opcode,
  input  logic signed [pcce_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pcce_pkg::COORD_W-1:0] coord_y,
  input  logic signed [pcce_pkg::COORD_W-1:0] coord_z,
  input  logic end_of_message,
  input  logic cfg_we,
  input  logic [pcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcce_pkg::CFG_W-1:0] cfg_data,
  output logic result_valid,
  output logic signed [pcce_pkg::CLEAR_W-1:0] clearance,
  output logic store_empty
);
  localparam int AW = (CLOUD_DEPTH > 1) ? $clog2(CLOUD_DEPTH) : 1;
  localparam int CW = $clog2(CLOUD_DEPTH + 1);
  localparam int PW = 2 * pcce_pkg::OFS_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F0 = 4'd1;
  localparam logic [3:0] S_F1 = 4'd2;
  localparam logic [3:0] S_F2 = 4'd3;
  localparam logic [3:0] S_F3 = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_RD = 4'd6;
  localparam logic [3:0] S_DX = 4'd7;
  localparam logic [3:0] S_DY = 4'd8;
  localparam logic [3:0] S_DZ = 4'd9;
  localparam logic [3:0] S_ACC = 4'd10;
  localparam logic [3:0] S_SUM = 4'd11;
  localparam logic [3:0] S_ROOT = 4'd12;
  localparam logic [3:0] S_SQRT = 4'd13;

  // configuration registers
  logic signed [pcce_pkg::COORD_W-1:0] vehicle_x, vehicle_y, vehicle_z;
  logic signed [pcce_pkg::HEAD_W-1:0] heading_x, heading_y, heading_z;
  logic [pcce_pkg::LIMIT_W-1:0] radius_limit;
  logic filter_on;

  logic [3:0] state;
  logic [CW-1:0] stored_count;
  logic inside_message, message_taken;
  logic signed [pcce_pkg::COORD_W-1:0] px, py, pz;
  logic last;
  logic [CW-1:0] idx;
  logic signed [pcce_pkg::OFS_W-1:0] rx, ry, rz;
  logic signed [PW+1:0] acc;
  logic [pcce_pkg::SQ_W-1:0] best;
  logic have_best;
  logic side_ok;

  pcce_pkg::mul_req_t mreq;
  logic signed [PW-1:0] prod;
  logic [pcce_pkg::COORD_W-1:0] rd_x, rd_y, rd_z;
  logic sq_go, sq_done;
  logic [pcce_pkg::ROOT_W-1:0] root;
  logic ram_we;
  logic store_ok;
  logic signed [pcce_pkg::ROOT_W:0] res;
  logic [pcce_pkg::SQ_W-1:0] dsum;
  logic scan_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_x <= '0;
      vehicle_y <= '0;
      vehicle_z <= '0;
      heading_x <= 16'sd16384;
      heading_y <= '0;
      heading_z <= '0;
      radius_limit <= 16'd2560;
      filter_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcce_pkg::REG_VX: vehicle_x <= cfg_data;
        pcce_pkg::REG_VY: vehicle_y <= cfg_data;
        pcce_pkg::REG_VZ: vehicle_z <= cfg_data;
        pcce_pkg::REG_HX: heading_x <= cfg_data[pcce_pkg::HEAD_W-1:0];
        pcce_pkg::REG_HY: heading_y <= cfg_data[pcce_pkg::HEAD_W-1:0];
        pcce_pkg::REG_HZ: heading_z <= cfg_data[pcce_pkg::HEAD_W-1:0];
        pcce_pkg::REG_LIMIT: radius_limit <= cfg_data[pcce_pkg::LIMIT_W-1:0];
        pcce_pkg::REG_FILTER: filter_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select, product is registered and comes back the next cycle
  always_comb begin
    mreq.a = rx;
    mreq.b = '0;
    case (state)
      S_F0: begin
        mreq.a = rx;
        mreq.b = pcce_pkg::OFS_W'(heading_x);
      end
      S_F1: begin
        mreq.a = ry;
        mreq.b = pcce_pkg::OFS_W'(heading_y);
      end
      S_F2: begin
        mreq.a = rz;
        mreq.b = pcce_pkg::OFS_W'(heading_z);
      end
      S_DY: begin
        mreq.a = rx;
        mreq.b = rx;
      end
      S_DZ: begin
        mreq.a = ry;
        mreq.b = ry;
      end
      S_ACC: begin
        mreq.a = rz;
        mreq.b = rz;
      end
      default: ;
    endcase
  end

  pcce_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  // point is kept only for a taken message, with room left, passing the filter
  assign store_ok = message_taken && (stored_count < CW'(CLOUD_DEPTH)) &&
                    (!filter_on || (side_ok && acc > (PW+2)'(pcce_pkg::FWD_MIN_Q22)));
  assign ram_we = (state == S_STORE) && store_ok;

  pcce_ram #(.WIDTH(pcce_pkg::COORD_W), .DEPTH(CLOUD_DEPTH)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(stored_count[AW-1:0]), .wdata(px),
    .raddr(idx[AW-1:0]), .rdata(rd_x));
  pcce_ram #(.WIDTH(pcce_pkg::COORD_W), .DEPTH(CLOUD_DEPTH)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(stored_count[AW-1:0]), .wdata(py),
    .raddr(idx[AW-1:0]), .rdata(rd_y));
  pcce_ram #(.WIDTH(pcce_pkg::COORD_W), .DEPTH(CLOUD_DEPTH)) u_ram_z (
    .clk(clk), .we(ram_we), .waddr(stored_count[AW-1:0]), .wdata(pz),
    .raddr(idx[AW-1:0]), .rdata(rd_z));

  // root of the final minimum, started once the scan is over
  assign sq_go = (state == S_ROOT);
  pcce_sqrt u_sqrt (.clk(clk), .rst(rst), .go(sq_go), .rad(best), .done(sq_done),
    .root(root));

  assign res = $signed({1'b0, root}) - pcce_pkg::TENTH_Q8;

  // squared distance of the current point: dx^2 + dy^2 in acc, dz^2 on the multiplier
  assign dsum = pcce_pkg::SQ_W'(acc + (PW+2)'(prod));
  // idx has already moved past the point being summed
  assign scan_last = (idx == stored_count);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stored_count <= '0;
      inside_message <= 1'b0;
      message_taken <= 1'b0;
      result_valid <= 1'b0;
      clearance <= '0;
      store_empty <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            px <= coord_x;
            py <= coord_y;
            pz <= coord_z;
            last <= end_of_message;
            rx <= pcce_pkg::OFS_W'(coord_x) - pcce_pkg::OFS_W'(vehicle_x);
            ry <= pcce_pkg::OFS_W'(coord_y) - pcce_pkg::OFS_W'(vehicle_y);
            rz <= pcce_pkg::OFS_W'(coord_z) - pcce_pkg::OFS_W'(vehicle_z);
            idx <= '0;
            have_best <= 1'b0;
            case (opcode)
              pcce_pkg::OP_LOAD: begin
                state <= S_F0;
              end
              pcce_pkg::OP_QUERY: begin
                // empty store answers the limit at once
                if (stored_count == '0) begin
                  result_valid <= 1'b1;
                  clearance <= pcce_pkg::CLEAR_W'(radius_limit);
                  store_empty <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              // clear leaves the message state alone
              pcce_pkg::OP_CLEAR: stored_count <= '0;
              default: ;
            endcase
          end
        end
        S_F0: begin
          // message acceptance decided at the first point
          if (!inside_message) begin
            message_taken <= (stored_count == '0);
          end
          side_ok <= (ry <= pcce_pkg::SIDE_MAX_Q8) && (ry >= -pcce_pkg::SIDE_MAX_Q8) &&
                     (rz <= pcce_pkg::SIDE_MAX_Q8) && (rz >= -pcce_pkg::SIDE_MAX_Q8);
          state <= filter_on ? S_F1 : S_STORE;
          inside_message <= !last;
        end
        S_F1: begin
          acc <= (PW+2)'(prod);
          state <= S_F2;
        end
        S_F2: begin
          acc <= acc + (PW+2)'(prod);
          state <= S_F3;
        end
        S_F3: begin
          acc <= acc + (PW+2)'(prod);
          state <= S_STORE;
        end
        S_STORE: begin
          // write strobe goes out this cycle, count is the write address
          if (store_ok) begin
            stored_count <= stored_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_RD: begin
          // first read in flight
          state <= S_DX;
        end
        S_DX: begin
          rx <= pcce_pkg::OFS_W'($signed(rd_x)) - pcce_pkg::OFS_W'(px);
          ry <= pcce_pkg::OFS_W'($signed(rd_y)) - pcce_pkg::OFS_W'(py);
          rz <= pcce_pkg::OFS_W'($signed(rd_z)) - pcce_pkg::OFS_W'(pz);
          idx <= idx + 1'b1;
          state <= S_DY;
        end
        S_DY: begin
          state <= S_DZ;
        end
        S_DZ: begin
          acc <= (PW+2)'(prod);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + (PW+2)'(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          // keep the minimum; the next point's read went out with the new idx
          if (!have_best || dsum < best) begin
            best <= dsum;
          end
          have_best <= 1'b1;
          state <= scan_last ? S_ROOT : S_DX;
        end
        S_ROOT: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          // less 0.1 m, clamped to the limit
          if (sq_done) begin
            result_valid <= 1'b1;
            if (res > $signed({11'b0, radius_limit})) begin
              clearance <= pcce_pkg::CLEAR_W'(radius_limit);
            end else begin
              clearance <= pcce_pkg::CLEAR_W'(res);
            end
            store_empty <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(CLOUD_DEPTH));
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (stored_count < CW'(CLOUD_DEPTH)));
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_IDLE));
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_SQRT);
  a_root_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT));
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  localparam int COORD_W = pcce_pkg::COORD_W;
  localparam int HEAD_W = pcce_pkg::HEAD_W;
  localparam int LIMIT_W = pcce_pkg::LIMIT_W;
  localparam int CLEAR_W = pcce_pkg::CLEAR_W;
  localparam int CFG_W = pcce_pkg::CFG_W;
  localparam int CFG_IDX_W = pcce_pkg::CFG_IDX_W;
  localparam int DEPTH = pcce_pkg::CLOUD_DEPTH_DEF;
  localparam logic [1:0] OP_SPARE = 2'd3;   // unused opcode, block ignores it
  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_POINTS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = pcce_pkg::OP_LOAD;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic end_of_message = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  logic signed [CLEAR_W-1:0] clearance;
  logic store_empty;

  // expected query answers, oldest first
  typedef struct {
    logic signed [CLEAR_W-1:0] clearance;
    logic store_empty;
  } answer_t;
  answer_t pending_answers[$];

  // shadow of the block: point store, message state, registers
  int cloud_x[DEPTH];
  int cloud_y[DEPTH];
  int cloud_z[DEPTH];
  int cloud_count;
  bit in_msg;
  bit msg_accepted;
  logic signed [COORD_W-1:0] veh_x, veh_y, veh_z;
  logic signed [HEAD_W-1:0] head_x, head_y, head_z;
  logic [LIMIT_W-1:0] max_clear;
  logic region_filter;

  int errors = 0;
  int items_sent = 0;
  int idle_pct = 0;   // chance in a hundred of a sender gap before each item

  point_cloud_clearance_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .end_of_message(end_of_message),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .clearance(clearance), .store_empty(store_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // nearest integer square root, ties impossible for integer input
  function automatic longint unsigned root_nearest(input longint unsigned d);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 27; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= d) r = t;
    end
    if (d - r * r > r) r++;
    return r;
  endfunction

  // region check around the vehicle: forward projection and side bands
  function automatic bit inside_region(input longint px, input longint py, input longint pz);
    longint rx, ry, rz, fwd;
    rx = px - longint'(veh_x);
    ry = py - longint'(veh_y);
    rz = pz - longint'(veh_z);
    fwd = rx * longint'(head_x) + ry * longint'(head_y) + rz * longint'(head_z);
    if (fwd <= longint'(pcce_pkg::FWD_MIN_Q22)) return 1'b0;
    if (ry > 25600 || ry < -25600) return 1'b0;
    if (rz > 25600 || rz < -25600) return 1'b0;
    return 1'b1;
  endfunction

  // applies one accepted item to the shadow, queues the answer for a query
  task automatic predict_clearance(input logic [1:0] op, input logic signed [COORD_W-1:0] px,
                                   input logic signed [COORD_W-1:0] py,
                                   input logic signed [COORD_W-1:0] pz, input logic eom);
    answer_t a;
    longint unsigned best, d;
    longint dx, dy, dz, clr;
    case (op)
      pcce_pkg::OP_LOAD: begin
        if (!in_msg) msg_accepted = (cloud_count == 0);
        if (msg_accepted && cloud_count < DEPTH &&
            (!region_filter || inside_region(px, py, pz))) begin
          cloud_x[cloud_count] = px;
          cloud_y[cloud_count] = py;
          cloud_z[cloud_count] = pz;
          cloud_count++;
        end
        in_msg = !eom;
      end
      pcce_pkg::OP_CLEAR: cloud_count = 0;
      pcce_pkg::OP_QUERY: begin
        if (cloud_count == 0) begin
          a.clearance = {1'b0, max_clear};
          a.store_empty = 1'b1;
        end else begin
          best = '1;
          for (int i = 0; i < cloud_count; i++) begin
            dx = longint'(cloud_x[i]) - px;
            dy = longint'(cloud_y[i]) - py;
            dz = longint'(cloud_z[i]) - pz;
            d = dx * dx + dy * dy + dz * dz;
            if (d < best) best = d;
          end
          clr = longint'(root_nearest(best)) - 26;
          if (clr > longint'(max_clear)) clr = max_clear;
          a.clearance = clr[CLEAR_W-1:0];
          a.store_empty = 1'b0;
        end
        pending_answers = {pending_answers, a};
      end
      default: ;
    endcase
  endtask

  // one item: optional sender gap, then hold start until the block takes it
  task automatic send_item(input logic [1:0] op, input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py,
                           input logic signed [COORD_W-1:0] pz, input logic eom);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    coord_x <= px;
    coord_y <= py;
    coord_z <= pz;
    end_of_message <= eom;
    do @(posedge clk); while (busy);
    predict_clearance(op, px, py, pz, eom);
    items_sent++;
  endtask

  // all answers in, then enough cycles for a trailing load to finish
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pcce_pkg::REG_VX: veh_x = value[COORD_W-1:0];
      pcce_pkg::REG_VY: veh_y = value[COORD_W-1:0];
      pcce_pkg::REG_VZ: veh_z = value[COORD_W-1:0];
      pcce_pkg::REG_HX: head_x = value[HEAD_W-1:0];
      pcce_pkg::REG_HY: head_y = value[HEAD_W-1:0];
      pcce_pkg::REG_HZ: head_z = value[HEAD_W-1:0];
      pcce_pkg::REG_LIMIT: max_clear = value[LIMIT_W-1:0];
      pcce_pkg::REG_FILTER: region_filter = value[0];
      default: ;
    endcase
  endtask

  // point near the vehicle so the filter bands are exercised, or anywhere
  function automatic logic signed [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] ctr);
    int ofs;
    case ($urandom_range(9))
      0, 1: return COORD_W'($urandom);
      2: return COORD_W'(ctr + ($urandom_range(1) ? 25600 : -25600) + $urandom_range(2) - 1);
      3: return COORD_W'(ctr + $signed($urandom_range(60000)) - 30000);
      default: begin
        ofs = $signed($urandom_range(4000)) - 2000;
        return COORD_W'(ctr + ofs);
      end
    endcase
  endfunction

  function automatic int pick_heading();
    case ($urandom_range(5))
      0: return 16384;
      1: return -16384;
      2: return 0;
      default: return $signed($urandom_range(32768)) - 16384;
    endcase
  endfunction

  // any register setting, extremes now and then
  task automatic shuffle_config();
    wait_idle();
    write_reg(pcce_pkg::REG_VX,
              $urandom_range(7) == 0 ? $urandom : $signed($urandom_range(8192)) - 4096);
    write_reg(pcce_pkg::REG_VY,
              $urandom_range(7) == 0 ? $urandom : $signed($urandom_range(8192)) - 4096);
    write_reg(pcce_pkg::REG_VZ,
              $urandom_range(7) == 0 ? $urandom : $signed($urandom_range(8192)) - 4096);
    write_reg(pcce_pkg::REG_HX, pick_heading());
    write_reg(pcce_pkg::REG_HY, pick_heading());
    write_reg(pcce_pkg::REG_HZ, pick_heading());
    case ($urandom_range(3))
      0: write_reg(pcce_pkg::REG_LIMIT, 0);
      1: write_reg(pcce_pkg::REG_LIMIT, 65535);
      default: write_reg(pcce_pkg::REG_LIMIT, $urandom_range(65535));
    endcase
    write_reg(pcce_pkg::REG_FILTER, $urandom_range(1));
  endtask

  // extremes, every opcode, message rules, filter boundaries
  task automatic test_directed();
    send_item(pcce_pkg::OP_QUERY, 0, 0, 0, 1'b0);                      // empty store
    send_item(pcce_pkg::OP_LOAD, 0, 0, 0, 1'b1);
    send_item(pcce_pkg::OP_QUERY, 0, 0, 0, 1'b0);                      // exact hit, negative
    send_item(pcce_pkg::OP_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_item(pcce_pkg::OP_QUERY, 24'sh800000, 24'sh800000, 24'sh800000, 1'b1);
    send_item(pcce_pkg::OP_LOAD, 100, 100, 100, 1'b1);                 // store not empty, dropped
    send_item(pcce_pkg::OP_QUERY, 100, 100, 100, 1'b0);
    send_item(OP_SPARE, 24'sh7FFFFF, 0, 24'sh800000, 1'b1);            // ignored
    send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    // query and clear inside a message, message stays taken
    send_item(pcce_pkg::OP_LOAD, 300, -300, 50, 1'b0);
    send_item(pcce_pkg::OP_QUERY, 310, -290, 40, 1'b0);
    send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    send_item(pcce_pkg::OP_LOAD, -700, 20, 5, 1'b0);
    // filter switched on partway through the message
    wait_idle();
    write_reg(pcce_pkg::REG_FILTER, 1);
    send_item(pcce_pkg::OP_LOAD, -12800, 0, 0, 1'b0);                  // on the forward bound, out
    send_item(pcce_pkg::OP_LOAD, -12799, 1, 0, 1'b0);
    send_item(pcce_pkg::OP_LOAD, 9, 25600, -25600, 1'b0);
    send_item(pcce_pkg::OP_LOAD, 9, 25601, 0, 1'b0);
    send_item(pcce_pkg::OP_LOAD, 9, 0, -25601, 1'b1);
    send_item(pcce_pkg::OP_QUERY, -12800, 0, 0, 1'b0);
    send_item(pcce_pkg::OP_QUERY, 9, 25601, 0, 1'b0);
    send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    // message filtered away entirely, next one is taken
    send_item(pcce_pkg::OP_LOAD, -20000, 0, 0, 1'b1);
    send_item(pcce_pkg::OP_LOAD, 1000, 0, 0, 1'b1);
    send_item(pcce_pkg::OP_QUERY, 0, 0, 0, 1'b0);
    wait_idle();
    write_reg(pcce_pkg::REG_LIMIT, 0);
    send_item(pcce_pkg::OP_QUERY, 1000, 0, 0, 1'b0);
    send_item(pcce_pkg::OP_QUERY, -5000, 0, 0, 1'b0);
    wait_idle();
    write_reg(pcce_pkg::REG_FILTER, 0);
    write_reg(pcce_pkg::REG_LIMIT, 65535);
    send_item(pcce_pkg::OP_QUERY, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
  endtask

  // one long message, then scans over the whole of it
  task automatic test_long_scan();
    wait_idle();
    write_reg(pcce_pkg::REG_FILTER, 0);
    idle_pct = 0;
    // close any open message so the next one starts fresh
    send_item(pcce_pkg::OP_LOAD, 0, 0, 0, 1'b1);
    send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    for (int i = 0; i < LONG_POINTS; i++)
      send_item(pcce_pkg::OP_LOAD, COORD_W'(i * 37 - 70000), COORD_W'(-i * 11), COORD_W'(i),
                i == LONG_POINTS - 1);
    send_item(pcce_pkg::OP_QUERY, COORD_W'(LONG_POINTS * 37 - 70000),
              COORD_W'(-LONG_POINTS * 11), COORD_W'(LONG_POINTS), 1'b0);
    send_item(pcce_pkg::OP_QUERY, 24'sh7FFFFF, 24'sh800000, 0, 1'b0);
    send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
  endtask

  // mostly well-formed messages with queries, some dropped messages and noise
  task automatic test_random_traffic();
    int points, queries, noise, stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        shuffle_config();
        case ($urandom_range(3))
          0: idle_pct = 0;
          1: idle_pct = 55;
          2: idle_pct = 29;
          default: idle_pct = $urandom_range(99);
        endcase
      end
      case ($urandom_range(9))
        0: begin
          noise = $urandom_range(1, 6);
          repeat (noise)
            send_item(2'($urandom_range(3)), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), 1'($urandom_range(1)));
        end
        1: begin
          // message with no clear before it, dropped if the store is loaded
          points = $urandom_range(1, 4);
          for (int i = 0; i < points; i++)
            send_item(pcce_pkg::OP_LOAD, pick_coord(veh_x), pick_coord(veh_y),
                      pick_coord(veh_z), i == points - 1);
          send_item(pcce_pkg::OP_QUERY, pick_coord(veh_x), pick_coord(veh_y),
                    pick_coord(veh_z), 1'b0);
        end
        default: begin
          send_item(pcce_pkg::OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), 1'($urandom_range(1)));
          points = $urandom_range(1, 12);
          for (int i = 0; i < points; i++) begin
            send_item(pcce_pkg::OP_LOAD, pick_coord(veh_x), pick_coord(veh_y),
                      pick_coord(veh_z), i == points - 1);
            if ($urandom_range(15) == 0)
              send_item(pcce_pkg::OP_QUERY, pick_coord(veh_x), pick_coord(veh_y),
                        pick_coord(veh_z), 1'b0);
            if ($urandom_range(40) == 0)
              send_item(pcce_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
          end
          queries = $urandom_range(1, 4);
          repeat (queries)
            send_item(pcce_pkg::OP_QUERY, pick_coord(veh_x), pick_coord(veh_y),
                      pick_coord(veh_z), 1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  // result checker, every strobe is one answer
  always @(posedge clk) begin
    answer_t a;
    if (!rst && result_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        a = pending_answers.pop_front();
        if (clearance !== a.clearance)
          report_mismatch($sformatf("clearance %0d, want %0d", clearance, a.clearance));
        if (store_empty !== a.store_empty)
          report_mismatch($sformatf("store_empty %0b, want %0b", store_empty, a.store_empty));
      end
    end
  end

  initial begin
    cloud_count = 0;
    in_msg = 1'b0;
    msg_accepted = 1'b0;
    veh_x = '0; veh_y = '0; veh_z = '0;
    head_x = 16384; head_y = '0; head_z = '0;
    max_clear = 2560;
    region_filter = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_long_scan();
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
